// ===== rtl/u8d_pkg.sv =====
// Shared types, codes and decode helpers for the UTF-8 stream decoder.
`timescale 1ns / 1ps
`default_nettype none

package u8d_pkg;

  localparam int unsigned CP_W    = 21;
  localparam int unsigned COUNT_W = 3;

  // Lead byte classes
  typedef enum logic [2:0] {
    LEAD_ASCII,
    LEAD_TWO,
    LEAD_THREE,
    LEAD_FOUR,
    LEAD_BAD
  } lead_class_t;

  // One decoded result as it leaves the block
  typedef struct packed {
    logic [CP_W-1:0]    code_point;
    logic               bad_sequence;
    logic [COUNT_W-1:0] byte_count;
    logic               last_of_run;
  } result_t;

  // Sequence state carried between bytes
  typedef struct packed {
    logic [1:0]         need;
    logic [COUNT_W-1:0] seq_len;
    logic [CP_W-1:0]    partial;
  } seq_state_t;

  // Results produced by one byte, in delivery order
  typedef struct packed {
    logic [1:0] num;
    result_t    res0;
    result_t    res1;
  } push_t;

  localparam result_t ERR_RESULT = '{code_point: '0, bad_sequence: 1'b1,
                                     byte_count: '0, last_of_run: 1'b0};

  localparam seq_state_t IDLE_STATE = '{need: '0, seq_len: '0, partial: '0};

  function automatic lead_class_t classify_lead(input logic [7:0] b);
    lead_class_t cls;
    if (b[7] == 1'b0) begin
      cls = LEAD_ASCII;
    end else if (b[7:5] == 3'b110) begin
      cls = LEAD_TWO;
    end else if (b[7:4] == 4'b1110) begin
      cls = LEAD_THREE;
    end else if (b[7:3] == 5'b11110) begin
      cls = LEAD_FOUR;
    end else begin
      cls = LEAD_BAD;
    end
    return cls;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/utf8_stream_decoder.sv =====
// Top level of the UTF-8 stream decoder.
//
// Input channel: one text byte per transaction (in_data_byte) with
// in_end_of_text marking the last byte of a text. Output channel: one
// decoded result per transaction: code point, error flag, byte count, and
// out_last_of_run on the final result caused by an input byte. A byte
// yields zero, one or two results.
// An accepted byte is registered in the input stage and decoded from there;
// its results are written into the result queue, which drives out_valid.
// Throughput: one byte per cycle while each byte yields at most one result and
// the receiver takes them; the single result port passes one result per cycle.
// The input stage advances only while the four-entry result queue has room
// for two results, so a stalled receiver fills the queue and then holds
// in_ready low; nothing is lost.
// Reset (synchronous, active low) closes any open sequence, empties the
// input stage and the result queue.
`timescale 1ns / 1ps
`default_nettype none

module utf8_stream_decoder
  import u8d_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [7:0]   in_data_byte,
  input  wire logic         in_end_of_text,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [CP_W-1:0]   out_code_point,
  output logic              out_bad_sequence,
  output logic [COUNT_W-1:0] out_byte_count,
  output logic              out_last_of_run
);

  logic       stg_valid_r, stg_valid_nxt;
  logic [7:0] stg_byte_r;
  logic       stg_eot_r;
  seq_state_t state_r, state_nxt;
  push_t      push;
  logic       room;
  logic       advance;
  result_t    out_res;

  assign advance       = stg_valid_r && room;
  assign in_ready      = !stg_valid_r || advance;
  assign stg_valid_nxt = (in_valid && in_ready) || (stg_valid_r && !advance);

  // Input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else begin
      stg_valid_r <= stg_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_byte_r <= in_data_byte;
      stg_eot_r  <= in_end_of_text;
    end
  end

  // Sequence state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= IDLE_STATE;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  u8d_decode u_decode (
    .data_byte   (stg_byte_r),
    .end_of_text (stg_eot_r),
    .state       (state_r),
    .state_nxt   (state_nxt),
    .push        (push)
  );

  u8d_result_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_en   (advance),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_code_point   = out_res.code_point;
  assign out_bad_sequence = out_res.bad_sequence;
  assign out_byte_count   = out_res.byte_count;
  assign out_last_of_run  = out_res.last_of_run;

endmodule

`default_nettype wire

// ===== rtl/u8d_decode.sv =====
// Combinational byte decoder: next sequence state and up to two results.
`timescale 1ns / 1ps
`default_nettype none

module u8d_decode
  import u8d_pkg::*;
(
  input  wire logic [7:0] data_byte,
  input  wire logic       end_of_text,
  input  wire seq_state_t state,
  output seq_state_t      state_nxt,
  output push_t           push
);

  logic        is_cont;
  lead_class_t cls;
  logic        a_vld;     // bad continuation error
  logic        b_vld;     // character, completion or invalid lead
  logic        c_vld;     // truncation at end of text
  result_t     b_res;
  result_t     second;
  seq_state_t  mid;
  logic [CP_W-1:0] shifted;

  assign is_cont = (data_byte[7:6] == 2'b10);
  assign cls     = classify_lead(data_byte);
  assign shifted = {state.partial[CP_W-7:0], data_byte[5:0]};

  // Main byte handling
  always_comb begin
    a_vld = 1'b0;
    b_vld = 1'b0;
    b_res = ERR_RESULT;
    mid   = IDLE_STATE;
    if (state.need != 2'd0 && is_cont) begin
      if (state.need == 2'd1) begin
        b_vld = 1'b1;
        b_res = '{code_point: shifted, bad_sequence: 1'b0,
                  byte_count: state.seq_len, last_of_run: 1'b0};
      end else begin
        mid.need    = state.need - 2'd1;
        mid.seq_len = state.seq_len;
        mid.partial = shifted;
      end
    end else begin
      // A non-continuation inside a sequence drops it and is taken as a lead
      a_vld = (state.need != 2'd0);
      case (cls)
        LEAD_ASCII: begin
          b_vld = 1'b1;
          b_res = '{code_point: CP_W'(data_byte[6:0]), bad_sequence: 1'b0,
                    byte_count: COUNT_W'(1), last_of_run: 1'b0};
        end
        LEAD_TWO: begin
          mid = '{need: 2'd1, seq_len: COUNT_W'(2), partial: CP_W'(data_byte[4:0])};
        end
        LEAD_THREE: begin
          mid = '{need: 2'd2, seq_len: COUNT_W'(3), partial: CP_W'(data_byte[3:0])};
        end
        LEAD_FOUR: begin
          mid = '{need: 2'd3, seq_len: COUNT_W'(4), partial: CP_W'(data_byte[2:0])};
        end
        default: begin
          b_vld = 1'b1;
          b_res = ERR_RESULT;
        end
      endcase
    end
  end

  // Truncation closes an open sequence at end of text
  assign c_vld     = end_of_text && (mid.need != 2'd0);
  assign state_nxt = c_vld ? IDLE_STATE : mid;

  // Pack results in order; b and c never occur together
  assign second = b_vld ? b_res : ERR_RESULT;

  always_comb begin
    push = '{num: 2'd0, res0: ERR_RESULT, res1: ERR_RESULT};
    if (a_vld) begin
      push.res0 = ERR_RESULT;
      if (b_vld || c_vld) begin
        push.num  = 2'd2;
        push.res1 = second;
        push.res1.last_of_run = 1'b1;
      end else begin
        push.num = 2'd1;
        push.res0.last_of_run = 1'b1;
      end
    end else if (b_vld || c_vld) begin
      push.num  = 2'd1;
      push.res0 = second;
      push.res0.last_of_run = 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/u8d_result_fifo.sv =====
// Four-entry result queue: takes up to two results per cycle, gives one.
`timescale 1ns / 1ps
`default_nettype none

module u8d_result_fifo
  import u8d_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push_en,
  input  wire push_t   push,
  output logic         room,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out_res
);

  localparam int unsigned DEPTH = 4;

  result_t    mem_r [DEPTH];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] count_r, count_nxt;
  logic [1:0] n_push;
  logic       pop;

  assign n_push    = push_en ? push.num : 2'd0;
  assign pop       = out_valid && out_ready;
  assign room      = (count_r <= 3'd2);
  assign out_valid = (count_r != 3'd0);
  assign out_res   = mem_r[rd_ptr_r];

  // Pointer and fill bookkeeping
  assign wr_ptr_nxt = wr_ptr_r + n_push;
  assign rd_ptr_nxt = rd_ptr_r + {1'b0, pop};
  assign count_nxt  = count_r + {1'b0, n_push} - {2'b00, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry writes
  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem_r[wr_ptr_r] <= push.res0;
    end
    if (n_push == 2'd2) begin
      mem_r[wr_ptr_r + 2'd1] <= push.res1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/u8d_checker.sv =====
// Port-level checks for the UTF-8 stream decoder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module u8d_checker
  import u8d_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [CP_W-1:0]    out_code_point,
  input wire logic               out_bad_sequence,
  input wire logic [COUNT_W-1:0] out_byte_count
);

  // No result is offered right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered after reset");

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // Error results carry no code point and no count
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_sequence |-> out_code_point == '0 && out_byte_count == '0)
    else $error("error result with payload");

  // Good results span one to four bytes; a single byte is ASCII
  a_good_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_bad_sequence |->
      (out_byte_count == 3'd1 && out_code_point < 21'd128) ||
      out_byte_count == 3'd2 || out_byte_count == 3'd3 || out_byte_count == 3'd4)
    else $error("bad byte count on good result");

endmodule

bind utf8_stream_decoder u8d_checker u_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_code_point   (out_code_point),
  .out_bad_sequence (out_bad_sequence),
  .out_byte_count   (out_byte_count)
);

`default_nettype wire

// ===== tb/utf8_stream_decoder_tb.sv =====
// Self-checking testbench for the UTF-8 stream decoder: directed and random bytes in, code points out.
`timescale 1ns / 1ps

module utf8_stream_decoder_tb;
  import u8d_pkg::*;

  localparam int N_TEXT_BYTES  = 1900;
  localparam int STALL_LIMIT   = 2000;
  localparam int DRAIN_CYCLES  = 16;
  localparam int MAX_REPORTS   = 10;

  // {end_of_text, data_byte}: character extremes, bad leads, broken and cut-off sequences
  localparam logic [8:0] DIRECTED_TEXT [25] = '{
    9'h000, 9'h07F,                          // zero byte, top of ASCII
    9'h0DF, 9'h0BF,                          // largest two-byte form
    9'h0EF, 9'h0BF, 9'h0BF,                  // largest three-byte form
    9'h0F7, 9'h0BF, 9'h0BF, 9'h1BF,          // all-ones four-byte form, end of text
    9'h080,                                  // stray continuation
    9'h0FF,                                  // 11111xxx lead
    9'h0C3, 9'h041,                          // ASCII breaks a sequence
    9'h0E2, 9'h082, 9'h0C3, 9'h0A9,          // new lead breaks a sequence, then completes
    9'h1E2,                                  // text ends right after a lead
    9'h0E2, 9'h082, 9'h1F0,                  // break plus truncation on one byte
    9'h0C3, 9'h0FF                           // break followed by invalid lead
  };

  typedef struct {
    logic [7:0] data_byte;
    logic       end_of_text;
  } text_byte_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [7:0]          in_data_byte;
  logic                in_end_of_text;
  logic                out_valid;
  logic                out_ready;
  logic [CP_W-1:0]     out_code_point;
  logic                out_bad_sequence;
  logic [COUNT_W-1:0]  out_byte_count;
  logic                out_last_of_run;

  text_byte_t text_q[$];
  result_t    cp_expect_q[$];
  result_t    step_res[$];

  // Decoder state mirror
  logic [1:0]         st_need;
  logic [COUNT_W-1:0] st_len;
  logic [CP_W-1:0]    st_partial;

  logic       in_taken;
  text_byte_t cur_byte;
  int         in_gap, in_calm, out_stall, out_calm;
  int         idle_cycles, mismatch_cnt, fail_cnt;
  int         bytes_sent, results_seen, error_results, double_steps;

  utf8_stream_decoder u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_end_of_text   (in_end_of_text),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_code_point   (out_code_point),
    .out_bad_sequence (out_bad_sequence),
    .out_byte_count   (out_byte_count),
    .out_last_of_run  (out_last_of_run)
  );

  always #1 clk = ~clk;

  // Mostly short gaps, a few long ones, and now and then a calm stretch with none
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 99) < 3) begin
      calm = $urandom_range(40, 160);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // Decode predictor
  // ---------------------------------------------------------------------------
  task automatic emit(input logic [CP_W-1:0] cp, input logic bad,
                      input logic [COUNT_W-1:0] cnt);
    result_t r;
    r.code_point   = cp;
    r.bad_sequence = bad;
    r.byte_count   = cnt;
    r.last_of_run  = 1'b0;
    step_res.push_back(r);
  endtask

  task automatic close_seq();
    st_need    = '0;
    st_len     = '0;
    st_partial = '0;
  endtask

  // Byte seen with no sequence open
  task automatic open_lead(input logic [7:0] b);
    lead_class_t cls;
    casez (b)
      8'b0???????: cls = LEAD_ASCII;
      8'b110?????: cls = LEAD_TWO;
      8'b1110????: cls = LEAD_THREE;
      8'b11110???: cls = LEAD_FOUR;
      default:     cls = LEAD_BAD;
    endcase
    case (cls)
      LEAD_ASCII: emit(CP_W'(b[6:0]), 1'b0, 3'd1);
      LEAD_TWO: begin
        st_partial = CP_W'(b[4:0]);
        st_need    = 2'd1;
        st_len     = 3'd2;
      end
      LEAD_THREE: begin
        st_partial = CP_W'(b[3:0]);
        st_need    = 2'd2;
        st_len     = 3'd3;
      end
      LEAD_FOUR: begin
        st_partial = CP_W'(b[2:0]);
        st_need    = 2'd3;
        st_len     = 3'd4;
      end
      default: emit('0, 1'b1, '0);
    endcase
  endtask

  // Work out every result one accepted byte causes and queue them
  task automatic decode_predict(input logic [7:0] b, input logic eot);
    step_res.delete();
    if (st_need != 2'd0) begin
      if (b[7:6] == 2'b10) begin
        st_partial = {st_partial[CP_W-7:0], b[5:0]};
        st_need    = st_need - 2'd1;
        if (st_need == 2'd0) begin
          emit(st_partial, 1'b0, st_len);
          close_seq();
        end
      end else begin
        // broken sequence: report it, then reuse the byte as a lead
        emit('0, 1'b1, '0);
        close_seq();
        open_lead(b);
      end
    end else begin
      open_lead(b);
    end
    // text ends with a sequence still open
    if (eot && st_need != 2'd0) begin
      emit('0, 1'b1, '0);
      close_seq();
    end
    if (step_res.size() > 0) step_res[step_res.size()-1].last_of_run = 1'b1;
    if (step_res.size() == 2) double_steps++;
    foreach (step_res[i]) cp_expect_q.push_back(step_res[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] b, input logic eot);
    text_byte_t t;
    t.data_byte   = b;
    t.end_of_text = eot;
    text_q.push_back(t);
  endtask

  // Byte idx of a well-formed len-byte sequence with random payload
  function automatic logic [7:0] seq_byte(input int len, input int idx);
    logic [7:0] r;
    r = 8'($urandom);
    if (idx > 0) return {2'b10, r[5:0]};
    case (len)
      1:       return {1'b0, r[6:0]};
      2:       return {3'b110, r[4:0]};
      3:       return {4'b1110, r[3:0]};
      default: return {5'b11110, r[2:0]};
    endcase
  endfunction

  // First 'take' bytes of a len-byte sequence; eot on the last one if asked
  task automatic push_seq(input int len, input int take, input logic eot_last);
    for (int i = 0; i < take; i++) push_byte(seq_byte(len, i), eot_last && (i == take - 1));
  endtask

  // ---------------------------------------------------------------------------
  // Reset, stimulus build and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int         r, len;
    logic       eot;
    logic [7:0] b;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data_byte   = '0;
    in_end_of_text = 1'b0;
    out_ready      = 1'b0;
    in_taken       = 1'b0;
    in_gap = 0; in_calm = 0; out_stall = 0; out_calm = 0;
    idle_cycles = 0; mismatch_cnt = 0; fail_cnt = 0;
    bytes_sent = 0; results_seen = 0; error_results = 0; double_steps = 0;
    close_seq();

    foreach (DIRECTED_TEXT[i]) push_byte(DIRECTED_TEXT[i][7:0], DIRECTED_TEXT[i][8]);

    // Mostly well-formed text with random code points; some cut-off and broken
    // sequences and raw noise mixed in
    while (text_q.size() < N_TEXT_BYTES + 25) begin
      r   = $urandom_range(0, 99);
      eot = ($urandom_range(0, 19) == 0);
      len = $urandom_range(1, 4);
      if (r < 78) begin
        push_seq(len, len, eot);
      end else if (r < 86) begin
        len = $urandom_range(2, 4);
        push_seq(len, $urandom_range(1, len - 1), 1'b1);
      end else if (r < 93) begin
        len = $urandom_range(2, 4);
        push_seq(len, $urandom_range(1, len - 1), 1'b0);
        b = 8'($urandom);
        if (b[7:6] == 2'b10) b[6] = 1'b1;
        push_byte(b, eot);
      end else begin
        push_byte(8'($urandom), eot);
      end
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (text_q.size() != 0 || in_valid || cp_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (cp_expect_q.size() != 0) begin
      $display("%0d expected results never arrived", cp_expect_q.size());
      fail_cnt++;
    end
    $display("Run: %0d text bytes decoded into %0d results (%0d flagged bad).",
             bytes_sent, results_seen, error_results);
    $display("Bytes that produced two results: %0d; mismatches: %0d.",
             double_steps, mismatch_cnt);
    if (fail_cnt == 0 && mismatch_cnt == 0) begin
      $display("** utf8_stream_decoder: PASSED **");
    end else begin
      $display("** utf8_stream_decoder: FAILED **");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Byte driver: holds a transaction until accepted, then idles or sends the next
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // waiting for acceptance
    end else if (in_gap > 0) begin
      in_valid <= 1'b0;
      in_gap--;
    end else if (text_q.size() > 0) begin
      cur_byte = text_q.pop_front();
      in_valid       <= 1'b1;
      in_data_byte   <= cur_byte.data_byte;
      in_end_of_text <= cur_byte.end_of_text;
      in_gap = pick_gap(in_calm);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Result receiver: random back-pressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (out_stall > 0) begin
      out_ready <= 1'b0;
      out_stall--;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 99) < 20) out_stall = pick_gap(out_calm);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check results, predict from accepted bytes, watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    if (rst_n) begin
      in_taken <= in_valid && in_ready;

      if (out_valid && out_ready) begin
        results_seen++;
        if (out_bad_sequence) error_results++;
        if (cp_expect_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("[%0t] unexpected result: cp=%h bad=%b cnt=%0d last=%b", $realtime,
                     out_code_point, out_bad_sequence, out_byte_count, out_last_of_run);
        end else begin
          want = cp_expect_q.pop_front();
          if (out_code_point !== want.code_point || out_bad_sequence !== want.bad_sequence ||
              out_byte_count !== want.byte_count || out_last_of_run !== want.last_of_run) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS)
              $display("[%0t] result %0d: exp cp=%h bad=%b cnt=%0d last=%b, got cp=%h bad=%b cnt=%0d last=%b",
                       $realtime, results_seen, want.code_point, want.bad_sequence,
                       want.byte_count, want.last_of_run, out_code_point, out_bad_sequence,
                       out_byte_count, out_last_of_run);
          end
        end
      end

      if (in_valid && in_ready) begin
        bytes_sent++;
        decode_predict(in_data_byte, in_end_of_text);
      end

      // no transaction while work is outstanding
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else if (text_q.size() != 0 || in_valid || cp_expect_q.size() != 0) begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("Timeout: %0d cycles without a transaction", idle_cycles);
          $display("** utf8_stream_decoder: FAILED **");
          $finish;
        end
      end
    end
  end

endmodule
